@@ rtl/ccpe_pkg.sv @@
// shared constants, codes and transaction types of the companion chip packet engine
// no dependencies; imported by every module of the engine
`timescale 1ns / 1ps
package ccpe_pkg;

   localparam int RX_DEPTH   = 24;
   localparam int TX_DEPTH   = 512;
   localparam int PRAM_DEPTH = 256;

   localparam int RX_AW   = $clog2(RX_DEPTH);
   localparam int RX_CW   = $clog2(RX_DEPTH + 1);
   localparam int TX_AW   = $clog2(TX_DEPTH);
   localparam int PRAM_AW = $clog2(PRAM_DEPTH);
   localparam int CNT_W   = 9;
   localparam int HEAD_N  = 6;

   // request operations
   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_PORT  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_FORCE = 2'd3;

   // port b pins
   localparam int PIN_FULL    = 4;
   localparam int PIN_SESSION = 5;

   // packet types and header values
   localparam logic [7:0] PKT_ADB      = 8'h00;
   localparam logic [7:0] PKT_LOCAL    = 8'h01;
   localparam logic [7:0] PKT_SECOND   = 8'h03;
   localparam logic [7:0] FLAG_NONE    = 8'h00;
   localparam logic [7:0] FLAG_TIMEOUT = 8'h02;
   localparam logic [7:0] CMD_NOP      = 8'h00;
   localparam logic [7:0] WIN_PAGE     = 8'h01;
   localparam logic [CNT_W-1:0] HDR_LEN = 9'd4;

   // pseudo commands
   localparam logic [7:0] CMD_AUTOPOLL  = 8'h01;
   localparam logic [7:0] CMD_WIN_RD    = 8'h02;
   localparam logic [7:0] CMD_RTC_RD    = 8'h03;
   localparam logic [7:0] CMD_PRAM_RD   = 8'h07;
   localparam logic [7:0] CMD_WIN_WR    = 8'h08;
   localparam logic [7:0] CMD_RTC_WR    = 8'h09;
   localparam logic [7:0] CMD_POWER_OFF = 8'h0A;
   localparam logic [7:0] CMD_PRAM_WR   = 8'h0C;
   localparam logic [7:0] CMD_DIAG      = 8'h0F;
   localparam logic [7:0] CMD_FLAGS_OFF = 8'h11;
   localparam logic [7:0] CMD_AP_ON     = 8'h14;
   localparam logic [7:0] CMD_TICK_MODE = 8'h1B;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic       sr_push;
      logic [7:0] sr_byte;
      logic       sess_level;
      logic       power_off;
      logic       autopoll_on;
      logic       tick_mode_on;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic restart;
      logic push;
   } rx_ctl_type;

   typedef struct packed {
      logic             we;
      logic [TX_AW-1:0] waddr;
      logic [7:0]       wdata;
      logic             re;
      logic [TX_AW-1:0] raddr;
   } tx_req_type;

   typedef struct packed {
      logic               we;
      logic [PRAM_AW-1:0] waddr;
      logic [7:0]         wdata;
      logic               re;
      logic [PRAM_AW-1:0] raddr;
   } pram_req_type;

endpackage

@@ rtl/ccpe_rx_buf.sv @@
// command receive buffer: byte store, fill count, fixed header taps and one read port
// depends on ccpe_pkg
`timescale 1ns / 1ps
module ccpe_rx_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  ccpe_pkg::rx_ctl_type    ctl,
   input  logic [7:0]              wdata,
   input  logic [ccpe_pkg::RX_AW-1:0] raddr,
   output logic [7:0]              rdata,
   output logic [ccpe_pkg::RX_CW-1:0] count,
   output logic [ccpe_pkg::HEAD_N-1:0][7:0] head
);
   import ccpe_pkg::*;

   logic [7:0]       mem [RX_DEPTH];
   logic [RX_CW-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctl.clear) begin
         cnt_ff <= '0;
      end else if (ctl.push) begin
         if (ctl.restart) begin
            cnt_ff <= RX_CW'(1);
         end else if (cnt_ff < RX_CW'(RX_DEPTH)) begin
            cnt_ff <= cnt_ff + RX_CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && !ctl.clear) begin
         if (ctl.restart) begin
            mem[0] <= wdata;
         end else if (cnt_ff < RX_CW'(RX_DEPTH)) begin
            mem[cnt_ff[RX_AW-1:0]] <= wdata;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < HEAD_N; i++) begin
         head[i] = mem[i];
      end
   end

   assign rdata = mem[raddr];
   assign count = cnt_ff;

endmodule

@@ rtl/ccpe_tx_buf.sv @@
// response byte store with one write port and a registered read port
// depends on ccpe_pkg
`timescale 1ns / 1ps
module ccpe_tx_buf (
   input  logic                   clock,
   input  ccpe_pkg::tx_req_type   req,
   output logic [7:0]             rdata
);
   import ccpe_pkg::*;

   logic [7:0] mem [TX_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rdata_ff <= mem[req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/ccpe_pram.sv @@
// parameter ram with per-entry valid bits so unwritten entries read as zero
// depends on ccpe_pkg
`timescale 1ns / 1ps
module ccpe_pram (
   input  logic                   clock,
   input  logic                   reset,
   input  ccpe_pkg::pram_req_type req,
   output logic [7:0]             rdata
);
   import ccpe_pkg::*;

   logic [7:0]            mem [PRAM_DEPTH];
   logic [PRAM_DEPTH-1:0] vld_ff;
   logic [7:0]            rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (req.we) begin
         vld_ff[req.waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rdata_ff <= vld_ff[req.raddr] ? mem[req.raddr] : 8'h00;
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/companion_chip_packet_engine.sv @@
// companion chip packet engine: result register, protocol state and packet sequencer
// depends on ccpe_pkg, ccpe_rx_buf, ccpe_tx_buf, ccpe_pram
// bytes, plain port writes and ticks give their result in the cycle after acceptance
// packet completion: 3 header writes, then for a body its bytes plus one end check, then one emit step
//   once the result register is free; later handshake bytes are read from the registered tx buffer
// throughput: one transaction in flight; reset clears protocol state, flags, clock, pram
`timescale 1ns / 1ps
module companion_chip_packet_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ccpe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ccpe_pkg::rsp_type rsp_data
);
   import ccpe_pkg::*;

   typedef enum logic [2:0] {ST_READY, ST_HDR, ST_BODY, ST_DONE, ST_RDTX} st_type;
   typedef enum logic [1:0] {PH_IDLE, PH_RECV, PH_SEND} ph_type;
   typedef enum logic [1:0] {BK_NONE, BK_CONST, BK_PRD, BK_PWR} bk_type;

   // control state
   st_type           st_ff, st_in;
   ph_type           ph_ff, ph_in;
   bk_type           bk_ff, bk_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [7:0]       port_ff, port_in;
   logic             xcvr_ff, xcvr_in;
   logic             ap_ff, ap_in;
   logic             tk_ff, tk_in;
   logic             pwr_ff, pwr_in;
   logic             pend_ff, pend_in;
   logic             rsp_vld_ff, rsp_vld_in;

   // payload state
   logic [31:0]      rtc_ff, rtc_in;
   logic [7:0]       htype_ff, htype_in;
   logic [7:0]       hflag_ff, hflag_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [15:0]      addr_ff, addr_in;
   logic [TX_AW-1:0] pidx_ff, pidx_in;
   logic             pzero_ff, pzero_in;
   rsp_type          rsp_ff, rsp_in;

   // memory ports
   rx_ctl_type                rx_ctl;
   logic [RX_AW-1:0]          rx_raddr;
   logic [7:0]                rx_rdata;
   logic [RX_CW-1:0]          rx_cnt;
   logic [HEAD_N-1:0][7:0]    rx_head;
   tx_req_type                txq;
   logic [7:0]                tx_rdata;
   pram_req_type              prq;
   logic [7:0]                pram_rdata;

   // helpers
   logic             out_free, accept;
   logic             s_rise, s_fall, f_fall;
   logic [CNT_W-1:0] pos_n, k_off;
   logic [15:0]      pa;
   logic [7:0]       rx_kind, pkt_cmd, hbyte, cbyte;
   logic             em, em_push, em_x, em_pwr;
   logic [7:0]       em_byte;

   ccpe_rx_buf u_rx (
      .clock (clock),
      .reset (reset),
      .ctl   (rx_ctl),
      .wdata (req_data.value),
      .raddr (rx_raddr),
      .rdata (rx_rdata),
      .count (rx_cnt),
      .head  (rx_head)
   );

   ccpe_tx_buf u_tx (
      .clock (clock),
      .req   (txq),
      .rdata (tx_rdata)
   );

   ccpe_pram u_pram (
      .clock (clock),
      .reset (reset),
      .req   (prq),
      .rdata (pram_rdata)
   );

   // output register frees when empty or being taken this cycle
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign req_stall = !((st_ff == ST_READY) && out_free);
   assign accept    = req_valid && !req_stall;

   // port b session and full pin transitions against the last written level
   assign s_rise = !port_ff[PIN_SESSION] &&  req_data.value[PIN_SESSION];
   assign s_fall =  port_ff[PIN_SESSION] && !req_data.value[PIN_SESSION];
   assign f_fall =  port_ff[PIN_FULL]    && !req_data.value[PIN_FULL];
   assign pos_n  = pos_ff + 9'd1;

   // packet header as received, with defaults for short packets
   assign rx_kind = (rx_cnt >= RX_CW'(1)) ? rx_head[0] : PKT_LOCAL;
   assign pkt_cmd = (rx_cnt >= RX_CW'(2)) ? rx_head[1] : CMD_NOP;

   // body walk: pram address and the data byte for writes
   assign pa       = addr_ff + 16'(k_off);
   assign k_off    = k_ff;
   assign rx_raddr = RX_AW'(k_ff + 9'd4);

   always_comb begin
      case (k_ff[1:0])
         2'd1:    hbyte = htype_ff;
         2'd2:    hbyte = hflag_ff;
         default: hbyte = cmd_ff;
      endcase
   end

   // constant body: clock seconds most significant first, or diagnostic zeros
   always_comb begin
      case (k_ff[1:0])
         2'd0:    cbyte = rtc_ff[31:24];
         2'd1:    cbyte = rtc_ff[23:16];
         2'd2:    cbyte = rtc_ff[15:8];
         default: cbyte = rtc_ff[7:0];
      endcase
      if (cmd_ff != CMD_RTC_RD) begin
         cbyte = 8'h00;
      end
   end

   always_comb begin
      st_in    = st_ff;
      ph_in    = ph_ff;
      bk_in    = bk_ff;
      k_in     = k_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      port_in  = port_ff;
      xcvr_in  = xcvr_ff;
      ap_in    = ap_ff;
      tk_in    = tk_ff;
      pwr_in   = pwr_ff;
      pend_in  = 1'b0;
      rtc_in   = rtc_ff;
      htype_in = htype_ff;
      hflag_in = hflag_ff;
      cmd_in   = cmd_ff;
      addr_in  = addr_ff;
      pidx_in  = pidx_ff;
      pzero_in = pzero_ff;
      rx_ctl   = '0;
      txq      = '0;
      prq      = '0;
      em       = 1'b0;
      em_push  = 1'b0;
      em_byte  = 8'h00;
      em_x     = xcvr_ff;
      em_pwr   = 1'b0;

      // pram read data lands in the cycle after its address
      if (pend_ff) begin
         txq.we    = 1'b1;
         txq.waddr = pidx_ff;
         txq.wdata = pzero_ff ? 8'h00 : pram_rdata;
      end

      case (st_ff)
         ST_READY: begin
            if (accept) begin
               case (req_data.operation)
                  OP_BYTE: begin
                     // a byte outside a receive starts a new one
                     rx_ctl.push    = 1'b1;
                     rx_ctl.restart = (ph_ff != PH_RECV);
                     ph_in          = PH_RECV;
                     em             = 1'b1;
                  end
                  OP_PORT: begin
                     port_in = req_data.value;
                     em      = 1'b1;
                     if (ph_ff == PH_RECV) begin
                        if (s_fall) begin
                           // session end: latch the header and set up the body walk
                           em       = 1'b0;
                           st_in    = ST_HDR;
                           k_in     = 9'd1;
                           ph_in    = PH_SEND;
                           pos_in   = '0;
                           pwr_in   = 1'b0;
                           bk_in    = BK_NONE;
                           len_in   = '0;
                           cnt_in   = HDR_LEN;
                           cmd_in   = pkt_cmd;
                           htype_in = PKT_LOCAL;
                           hflag_in = FLAG_NONE;
                           addr_in  = (rx_cnt >= RX_CW'(4)) ? {rx_head[2], rx_head[3]} : 16'h0000;
                           if (rx_kind == PKT_ADB) begin
                              // adb traffic is not served: timeout reply
                              htype_in = PKT_ADB;
                              hflag_in = FLAG_TIMEOUT;
                           end else if (rx_kind == PKT_LOCAL) begin
                              case (pkt_cmd)
                                 CMD_RTC_RD: begin
                                    bk_in  = BK_CONST;
                                    len_in = 9'd4;
                                    cnt_in = HDR_LEN + 9'd4;
                                 end
                                 CMD_DIAG: begin
                                    bk_in  = BK_CONST;
                                    len_in = 9'd2;
                                    cnt_in = HDR_LEN + 9'd2;
                                 end
                                 CMD_RTC_WR: begin
                                    if (rx_cnt >= RX_CW'(6)) begin
                                       rtc_in = {rx_head[2], rx_head[3], rx_head[4], rx_head[5]};
                                    end
                                 end
                                 CMD_WIN_RD, CMD_PRAM_RD: begin
                                    bk_in  = BK_PRD;
                                    len_in = 9'd256;
                                    cnt_in = HDR_LEN + 9'd256;
                                 end
                                 CMD_WIN_WR, CMD_PRAM_WR: begin
                                    // data follows the two address bytes
                                    if (rx_cnt >= RX_CW'(4)) begin
                                       bk_in  = BK_PWR;
                                       len_in = 9'(rx_cnt) - 9'd4;
                                    end
                                 end
                                 CMD_AUTOPOLL: begin
                                    ap_in = (rx_cnt >= RX_CW'(3)) ? (rx_head[2] != 8'h00) : 1'b1;
                                 end
                                 CMD_AP_ON: begin
                                    ap_in = 1'b1;
                                 end
                                 CMD_TICK_MODE: begin
                                    tk_in = (rx_cnt >= RX_CW'(3)) ? (rx_head[2] != 8'h00) : 1'b1;
                                 end
                                 CMD_POWER_OFF: begin
                                    pwr_in = 1'b1;
                                 end
                                 CMD_FLAGS_OFF: begin
                                    ap_in = 1'b0;
                                    tk_in = 1'b0;
                                 end
                                 default: begin
                                 end
                              endcase
                           end
                        end
                     end else if (ph_ff == PH_SEND) begin
                        if (s_fall) begin
                           ph_in   = PH_IDLE;
                           xcvr_in = 1'b1;
                           em_x    = 1'b1;
                        end else if (s_rise || f_fall) begin
                           pos_in = pos_n;
                           if (pos_n < cnt_ff) begin
                              // next byte comes from the response memory
                              em        = 1'b0;
                              txq.re    = 1'b1;
                              txq.raddr = TX_AW'(pos_n);
                              st_in     = ST_RDTX;
                           end else begin
                              ph_in   = PH_IDLE;
                              xcvr_in = 1'b1;
                              em_x    = 1'b1;
                           end
                        end
                     end else if (s_rise) begin
                        ph_in        = PH_RECV;
                        rx_ctl.clear = 1'b1;
                     end
                  end
                  default: begin
                     // ticks only go out on an idle bus
                     em = 1'b1;
                     if ((ph_ff != PH_RECV) && (ph_ff != PH_SEND) &&
                         ((req_data.operation == OP_FORCE) || tk_ff)) begin
                        txq.we    = 1'b1;
                        txq.waddr = TX_AW'(1);
                        txq.wdata = PKT_SECOND;
                        cnt_in    = 9'd2;
                        pos_in    = '0;
                        ph_in     = PH_SEND;
                        xcvr_in   = 1'b0;
                        em_x      = 1'b0;
                        em_push   = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_HDR: begin
            // byte zero is the constant attention byte and is never read back
            txq.we    = 1'b1;
            txq.waddr = TX_AW'(k_ff);
            txq.wdata = hbyte;
            k_in      = k_ff + 9'd1;
            if (k_ff[1:0] == 2'd3) begin
               k_in  = '0;
               st_in = (bk_ff == BK_NONE) ? ST_DONE : ST_BODY;
            end
         end
         ST_BODY: begin
            if (k_ff == len_ff) begin
               st_in = ST_DONE;
            end else begin
               k_in = k_ff + 9'd1;
               case (bk_ff)
                  BK_CONST: begin
                     txq.we    = 1'b1;
                     txq.waddr = TX_AW'(HDR_LEN + k_ff);
                     txq.wdata = cbyte;
                  end
                  BK_PRD: begin
                     prq.re    = 1'b1;
                     prq.raddr = pa[7:0];
                     pend_in   = 1'b1;
                     pidx_in   = TX_AW'(HDR_LEN + k_ff);
                     pzero_in  = (cmd_ff == CMD_WIN_RD) && (pa[15:8] != WIN_PAGE);
                  end
                  BK_PWR: begin
                     prq.we    = (cmd_ff == CMD_PRAM_WR) || (pa[15:8] == WIN_PAGE);
                     prq.waddr = pa[7:0];
                     prq.wdata = rx_rdata;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (out_free) begin
               em      = 1'b1;
               em_push = 1'b1;
               em_x    = 1'b0;
               em_pwr  = pwr_ff;
               xcvr_in = 1'b0;
               st_in   = ST_READY;
            end
         end
         ST_RDTX: begin
            if (out_free) begin
               em      = 1'b1;
               em_push = 1'b1;
               em_byte = tx_rdata;
               em_x    = (pos_ff + 9'd1 == cnt_ff);
               xcvr_in = em_x;
               st_in   = ST_READY;
            end
         end
         default: begin
            st_in = ST_READY;
         end
      endcase

      // result register: load on a finished transaction, hold while stalled
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      rsp_in     = rsp_ff;
      if (em) begin
         rsp_vld_in          = 1'b1;
         rsp_in.sr_push      = em_push;
         rsp_in.sr_byte      = em_byte;
         rsp_in.sess_level   = em_x;
         rsp_in.power_off    = em_pwr;
         rsp_in.autopoll_on  = ap_in;
         rsp_in.tick_mode_on = tk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_READY;
         ph_ff      <= PH_IDLE;
         bk_ff      <= BK_NONE;
         k_ff       <= '0;
         len_ff     <= '0;
         cnt_ff     <= '0;
         pos_ff     <= '0;
         port_ff    <= '0;
         xcvr_ff    <= 1'b1;
         ap_ff      <= 1'b0;
         tk_ff      <= 1'b0;
         pwr_ff     <= 1'b0;
         pend_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
         rtc_ff     <= '0;
      end else begin
         st_ff      <= st_in;
         ph_ff      <= ph_in;
         bk_ff      <= bk_in;
         k_ff       <= k_in;
         len_ff     <= len_in;
         cnt_ff     <= cnt_in;
         pos_ff     <= pos_in;
         port_ff    <= port_in;
         xcvr_ff    <= xcvr_in;
         ap_ff      <= ap_in;
         tk_ff      <= tk_in;
         pwr_ff     <= pwr_in;
         pend_ff    <= pend_in;
         rsp_vld_ff <= rsp_vld_in;
         rtc_ff     <= rtc_in;
      end
      htype_ff <= htype_in;
      hflag_ff <= hflag_in;
      cmd_ff   <= cmd_in;
      addr_ff  <= addr_in;
      pidx_ff  <= pidx_in;
      pzero_ff <= pzero_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // body walk never runs past its length
   a_body_len: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_BODY) |-> (k_ff <= len_ff))
      else $error("body index beyond length");

   // a send waiting on the host always has a byte position inside the response
   a_send_pos: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == ST_READY) && (ph_ff == PH_SEND)) |-> (pos_ff < cnt_ff))
      else $error("send position outside response");

   // response length stays within header plus a full pram page
   a_tx_len: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= HDR_LEN + 9'd256))
      else $error("response length too large");

   // a pending pram read is only issued by the body walk
   a_pend: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ($past(st_ff) == ST_BODY) && ($past(bk_ff) == BK_PRD))
      else $error("stray pram read");

endmodule

@@ test/ccpe_checker.sv @@
// transaction monitor and scoreboard for the companion chip packet engine
// depends on ccpe_pkg; predicts one response per accepted request
`timescale 1ns / 1ps
module ccpe_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  ccpe_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  ccpe_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import ccpe_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RECV = 2'd1;
   localparam logic [1:0] PH_SEND = 2'd2;

   logic [1:0]  phase;
   logic [7:0]  rx_mem [RX_DEPTH];
   int          rx_num;
   logic [7:0]  tx_mem [TX_DEPTH];
   int          tx_num;
   int          tx_idx;
   logic [7:0]  port_q;
   logic        xcvr_q, ap_q, tick_q;
   logic [7:0]  pram_m [PRAM_DEPTH];
   logic [31:0] seconds;
   logic        pushed, pwr;
   logic [7:0]  pbyte;
   rsp_type     rsp_queue[$];

   function automatic logic [7:0] rx_at(int i);
      return (i < rx_num) ? rx_mem[i] : 8'h00;
   endfunction

   task automatic push_byte(int idx);
      xcvr_q = (idx + 1 == tx_num);
      pushed = 1'b1;
      pbyte  = (idx < TX_DEPTH) ? tx_mem[idx] : 8'h00;
   endtask

   task automatic begin_send();
      phase  = PH_SEND;
      tx_idx = 0;
      push_byte(0);
   endtask

   task automatic put_header(logic [7:0] ty, logic [7:0] fl, logic [7:0] cm);
      tx_mem[0] = 8'h00; tx_mem[1] = ty; tx_mem[2] = fl; tx_mem[3] = cm;
      tx_num = 4;
   endtask

   task automatic run_pseudo_cmd();
      logic [7:0]  cm;
      int          dlen;
      logic [15:0] addr, a;
      cm   = (rx_num >= 2) ? rx_mem[1] : CMD_NOP;
      dlen = (rx_num >= 2) ? rx_num - 2 : 0;
      addr = (dlen >= 2) ? {rx_at(2), rx_at(3)} : 16'h0;
      put_header(PKT_LOCAL, FLAG_NONE, cm);
      case (cm)
         CMD_RTC_RD: begin
            for (int k = 0; k < 4; k++) tx_mem[tx_num++] = seconds[31 - 8*k -: 8];
         end
         CMD_RTC_WR: if (dlen >= 4) seconds = {rx_at(2), rx_at(3), rx_at(4), rx_at(5)};
         CMD_WIN_RD: begin
            for (int k = 0; k < 256 && tx_num < TX_DEPTH; k++) begin
               a = addr + k[15:0];
               tx_mem[tx_num++] = (a[15:8] == WIN_PAGE) ? pram_m[a[7:0]] : 8'h00;
            end
         end
         CMD_PRAM_RD: begin
            for (int k = 0; k < 256 && tx_num < TX_DEPTH; k++)
               tx_mem[tx_num++] = pram_m[8'(addr + k[15:0])];
         end
         CMD_WIN_WR: begin
            for (int k = 2; k < dlen; k++) begin
               a = addr + 16'(k - 2);
               if (a[15:8] == WIN_PAGE) pram_m[a[7:0]] = rx_mem[2 + k];
            end
         end
         CMD_PRAM_WR: begin
            for (int k = 2; k < dlen; k++) pram_m[8'(addr + 16'(k - 2))] = rx_mem[2 + k];
         end
         CMD_AUTOPOLL:  ap_q = (dlen >= 1) ? (rx_mem[2] != 0) : 1'b1;
         CMD_AP_ON:     ap_q = 1'b1;
         CMD_TICK_MODE: tick_q = (dlen >= 1) ? (rx_mem[2] != 0) : 1'b1;
         CMD_POWER_OFF: pwr = 1'b1;
         CMD_DIAG: begin
            tx_mem[tx_num++] = 8'h00;
            tx_mem[tx_num++] = 8'h00;
         end
         CMD_FLAGS_OFF: begin
            ap_q = 1'b0; tick_q = 1'b0;
         end
         default: ;
      endcase
      begin_send();
   endtask

   task automatic finish_packet();
      logic [7:0] ty, cm;
      ty = (rx_num >= 1) ? rx_mem[0] : PKT_LOCAL;
      cm = (rx_num >= 2) ? rx_mem[1] : CMD_NOP;
      if (ty == PKT_ADB) begin
         put_header(PKT_ADB, FLAG_TIMEOUT, cm);
         begin_send();
      end else if (ty == PKT_LOCAL) begin
         run_pseudo_cmd();
      end else begin
         put_header(PKT_LOCAL, FLAG_NONE, cm);
         begin_send();
      end
   endtask

   task automatic try_tick();
      if (phase == PH_RECV || phase == PH_SEND) return;
      tx_mem[0] = 8'h00; tx_mem[1] = PKT_SECOND; tx_num = 2;
      begin_send();
   endtask

   task automatic port_edge(logic [7:0] v);
      logic s_rise, s_fall, f_fall;
      s_rise = !port_q[PIN_SESSION] && v[PIN_SESSION];
      s_fall = port_q[PIN_SESSION] && !v[PIN_SESSION];
      f_fall = port_q[PIN_FULL] && !v[PIN_FULL];
      port_q = v;
      if (phase == PH_RECV) begin
         if (s_fall) finish_packet();
      end else if (phase == PH_SEND) begin
         if (s_fall) begin
            phase = PH_IDLE; xcvr_q = 1'b1;
         end else if (s_rise || f_fall) begin
            tx_idx = (tx_idx + 1) & 9'h1FF;
            if (tx_idx < tx_num) push_byte(tx_idx);
            else begin
               phase = PH_IDLE; xcvr_q = 1'b1;
            end
         end
      end else if (s_rise) begin
         phase = PH_RECV; rx_num = 0;
      end
   endtask

   // one request in, one predicted response out
   task automatic predict_response(req_type r);
      rsp_type e;
      pushed = 1'b0; pbyte = 8'h00; pwr = 1'b0;
      case (r.operation)
         OP_BYTE: begin
            if (phase != PH_RECV) begin
               phase = PH_RECV; rx_num = 0;
            end
            if (rx_num < RX_DEPTH) rx_mem[rx_num++] = r.value;
         end
         OP_PORT:  port_edge(r.value);
         OP_TICK:  if (tick_q) try_tick();
         default:  try_tick();
      endcase
      e.sr_push = pushed; e.sr_byte = pushed ? pbyte : 8'h00;
      e.sess_level = xcvr_q; e.power_off = pwr;
      e.autopoll_on = ap_q; e.tick_mode_on = tick_q;
      rsp_queue.push_back(e);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      fail_count++;
   endtask

   initial begin
      phase = PH_IDLE; rx_num = 0; tx_num = 0; tx_idx = 0; port_q = 8'h00;
      xcvr_q = 1'b1; ap_q = 1'b0; tick_q = 1'b0; seconds = 32'h0;
      foreach (pram_m[i]) pram_m[i] = 8'h00;
      foreach (tx_mem[i]) tx_mem[i] = 8'h00;
      foreach (rx_mem[i]) rx_mem[i] = 8'h00;
   end

   always @(posedge clock) begin
      rsp_type w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_queue.size() == 0) report_mismatch("unexpected response", 1, 0);
            else begin
               w = rsp_queue.pop_front();
               if (rsp_data.sr_push !== w.sr_push)
                  report_mismatch("sr_push", rsp_data.sr_push, w.sr_push);
               if (rsp_data.sr_byte !== w.sr_byte)
                  report_mismatch("sr_byte", rsp_data.sr_byte, w.sr_byte);
               if (rsp_data.sess_level !== w.sess_level)
                  report_mismatch("sess_level", rsp_data.sess_level, w.sess_level);
               if (rsp_data.power_off !== w.power_off)
                  report_mismatch("power_off", rsp_data.power_off, w.power_off);
               if (rsp_data.autopoll_on !== w.autopoll_on)
                  report_mismatch("autopoll_on", rsp_data.autopoll_on, w.autopoll_on);
               if (rsp_data.tick_mode_on !== w.tick_mode_on)
                  report_mismatch("tick_mode_on", rsp_data.tick_mode_on, w.tick_mode_on);
            end
         end
         if (req_valid && !req_stall) predict_response(req_data);
      end
      pending_count = rsp_queue.size();
   end
endmodule

@@ test/tb.sv @@
// stimulus top for the companion chip packet engine regression
// depends on ccpe_pkg, ccpe_checker and the engine rtl
`timescale 1ns / 1ps
module tb;
   import ccpe_pkg::*;

   logic    clock, reset;
   logic    req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   int      fail_count, pending_count;

   // idle odds in percent, changed per phase
   int      send_idle, recv_idle;
   bit      hold_recv;
   int      quiet_cycles;
   int      items_sent;
   logic [7:0] port_level;

   companion_chip_packet_engine dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   ccpe_checker chk (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .fail_count, .pending_count
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver side: random stall, or a long hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= hold_recv || ($urandom_range(99) < recv_idle);
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // drive one transaction and wait for its acceptance; valid stays up until the next
   // call or a drain lowers it, so it changes at most once per falling edge
   task automatic send_req(logic [1:0] op, logic [7:0] v);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{operation: op, value: v};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic set_port(logic [7:0] v);
      port_level = v;
      send_req(OP_PORT, v);
   endtask

   // host side of a full packet: session rise, bytes, session fall, then clock bytes out
   task automatic host_packet(logic [7:0] bytes[$], int pulls);
      logic [7:0] other;
      other = port_level & ~8'h30;
      set_port(other | 8'h20);
      foreach (bytes[i]) send_req(OP_BYTE, bytes[i]);
      set_port(other);
      for (int k = 0; k < pulls; k++) begin
         if ($urandom_range(1)) begin
            set_port(other | 8'h20);
            set_port(other);
         end else begin
            set_port(other | 8'h10);
            set_port(other);
         end
      end
   endtask

   task automatic random_packet();
      logic [7:0] b[$];
      logic [7:0] cmds[13];
      int n, pulls;
      cmds = '{CMD_AUTOPOLL, CMD_WIN_RD, CMD_RTC_RD, CMD_PRAM_RD, CMD_WIN_WR, CMD_RTC_WR,
               CMD_POWER_OFF, CMD_PRAM_WR, CMD_DIAG, CMD_FLAGS_OFF, CMD_AP_ON, CMD_TICK_MODE,
               CMD_NOP};
      n = $urandom_range(RX_DEPTH + 3);
      for (int i = 0; i < n; i++) b.push_back(8'($urandom));
      if (n > 0 && $urandom_range(9) < 8) b[0] = PKT_LOCAL;
      else if (n > 0 && $urandom_range(1)) b[0] = PKT_ADB;
      if (n > 1 && $urandom_range(9) < 8) b[1] = cmds[$urandom_range(12)];
      if (n > 3 && $urandom_range(1)) b[2] = $urandom_range(1) ? WIN_PAGE : b[2];
      pulls = $urandom_range(1) ? $urandom_range(8) : $urandom_range(100);
      host_packet(b, pulls);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [7:0] pk[$];
      int sent;
      reset = 1'b1; req_valid = 1'b0; req_data = '0; hold_recv = 1'b0;
      send_idle = 0; recv_idle = 0; port_level = 8'h00; items_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: pram, window, clock, tick mode and power commands, short data, window edges, ticks, abandoned sends
      send_req(OP_FORCE, 8'h00);
      set_port(8'h10); set_port(8'h00);
      set_port(8'h20); set_port(8'h00); set_port(8'h00);
      pk = {}; host_packet(pk, 2);
      pk = '{8'h01}; host_packet(pk, 1);
      pk = '{PKT_LOCAL, CMD_PRAM_WR, 8'h00, 8'hFE, 8'hAA, 8'h55, 8'hFF};
      host_packet(pk, 1);
      pk = '{PKT_LOCAL, CMD_WIN_WR, 8'h01, 8'hFF, 8'h11, 8'h22};
      host_packet(pk, 1);
      pk = '{PKT_LOCAL, CMD_WIN_RD, 8'hFF, 8'hFF}; host_packet(pk, 262);
      pk = '{PKT_LOCAL, CMD_PRAM_RD, 8'hFF}; host_packet(pk, 20);
      pk = '{PKT_LOCAL, CMD_RTC_WR, 8'hFF, 8'h00, 8'h80, 8'h01}; host_packet(pk, 1);
      pk = '{PKT_LOCAL, CMD_RTC_RD}; host_packet(pk, 9);
      pk = '{PKT_LOCAL, CMD_TICK_MODE}; host_packet(pk, 5);
      send_req(OP_TICK, 8'hFF); set_port(8'h20);
      pk = '{PKT_LOCAL, CMD_POWER_OFF}; host_packet(pk, 1);
      pk = '{PKT_ADB, 8'h3C}; host_packet(pk, 4);
      pk = '{8'hFF, 8'h7E}; host_packet(pk, 4);
      send_req(OP_BYTE, 8'hFF);
      send_req(OP_BYTE, 8'h00);
      drain();

      // random phases; the middle one holds the receiver off for a long stretch
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 6 : (ph == 1) ? 75 : 0;
         recv_idle = (ph == 0) ? 75 : (ph == 1) ? 6 : 0;
         sent = items_sent;
         if (ph == 1) fork
            begin
               hold_recv = 1'b1;
               repeat (400) @(posedge clock);
               hold_recv = 1'b0;
            end
         join_none
         while (items_sent - sent < 350) begin
            if ($urandom_range(9) < 7) begin
               random_packet();
            end else begin
               send_req(2'($urandom_range(3)), 8'($urandom));
            end
         end
         drain();
      end

      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/ccpe_pkg.sv
rtl/ccpe_rx_buf.sv
rtl/ccpe_tx_buf.sv
rtl/ccpe_pram.sv
rtl/companion_chip_packet_engine.sv
test/ccpe_checker.sv
test/tb.sv
